// File: rtl/core/samu_pkg.sv
// shared constants, types and arithmetic helpers for the apparent magnitude pipeline
package samu_pkg;

    // fixed-point formats
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int MAG_FRAC_BITS   = 10;
    localparam int LOG_FB          = 20;
    localparam int SUM_FB          = 48;

    // port widths
    localparam int MAG_W   = 15;
    localparam int RANGE_W = 30;
    localparam int ANG_W   = 19;
    localparam int OUT_W   = 18;

    // pi rounded to the angle format
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PA64   =
        (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam int D_W = ANG_W;
    localparam logic [D_W-1:0] PA = PA64[D_W-1:0];

    // squared angle, taken to LOG_FB fraction bits
    localparam int U_SH = 2 * ANGLE_FRAC_BITS - LOG_FB;
    localparam logic [2*D_W-1:0] U_RND = (U_SH > 0) ? ((2*D_W)'(1) << (U_SH - 1)) : '0;
    localparam int U_W = 2 * D_W - U_SH;

    // polynomial accumulator, Q.40
    localparam int ACC_W   = 41;
    localparam int HORNER_N = 6;
    localparam logic signed [ACC_W-1:0] POLY_Q40 [7] = '{
        41'sd366503875925, -41'sd36650387593, 41'sd1308942414, -41'sd24239674,
        41'sd275451, -41'sd2119, 41'sd12
    };

    // log2 unit
    localparam int LX_W   = 40;
    localparam int P_W    = 6;
    localparam int MANT_W = 31;

    // log-domain terms and weights
    localparam int LV_W = 32;
    localparam logic signed [LV_W-1:0] LOG2_FLOOR = -32'sd34832941;
    localparam logic signed [LV_W-1:0] K5  = 32'sd404035621;
    localparam logic signed [LV_W-1:0] K25 = 32'sd202017810;
    localparam int SUM_W = 64;
    localparam int RND_SH = SUM_FB - MAG_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) <<< (OUT_W - 1));
    localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) <<< (OUT_W - 1)) - 1;

    // pipeline depth, acceptance to result strobe
    localparam int LAT_POLY  = 2 + HORNER_N;
    localparam int LAT_LOG   = LOG_FB + 1;
    localparam int LAT_COMB  = 4;
    localparam int LATENCY   = LAT_POLY + LAT_LOG + LAT_COMB;

    typedef struct packed {
        logic [P_W-1:0]    p;
        logic [LOG_FB-1:0] frac;
    } log_res_t;

    // one horner step: c + acc*u, product rounded half away from zero
    function automatic logic signed [ACC_W-1:0] horner_step(
        input logic signed [ACC_W-1:0] acc,
        input logic [U_W-1:0]          u,
        input logic signed [ACC_W-1:0] c
    );
        logic [ACC_W-1:0]     mag;
        logic [ACC_W+U_W-1:0] prod;
        logic [ACC_W-1:0]     q;
        mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        prod = (ACC_W+U_W)'(mag) * (ACC_W+U_W)'(u);
        prod = prod + ((ACC_W+U_W)'(1) << (LOG_FB - 1));
        q    = ACC_W'(prod >> LOG_FB);
        return acc[ACC_W-1] ? (c - $signed(q)) : (c + $signed(q));
    endfunction

    // log2 value in Q.LOG_FB, less a power-of-two scale
    function automatic logic signed [LV_W-1:0] log_value(
        input log_res_t res,
        input int       scale
    );
        logic signed [LV_W-1:0] ip;
        ip = $signed(LV_W'(res.p)) - LV_W'(scale);
        return (ip <<< LOG_FB) + $signed(LV_W'(res.frac));
    endfunction

endpackage

// File: rtl/core/samu_poly.sv
// phase clamp, squared angle and horner evaluation of the diffuse-sphere polynomial
module samu_poly
    import samu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic signed [MAG_W-1:0] std_mag,
    input  logic [RANGE_W-1:0]      range_m,
    input  logic signed [ANG_W-1:0] phase_angle,
    output logic                    out_vld,
    output logic signed [MAG_W-1:0] out_mag,
    output logic [RANGE_W-1:0]      out_range,
    output logic [D_W-1:0]          out_d,
    output logic signed [ACC_W-1:0] out_acc
);

    logic                    v0_reg, v1_reg;
    logic signed [MAG_W-1:0] mag0_reg, mag1_reg;
    logic [RANGE_W-1:0]      rng0_reg, rng1_reg;
    logic [D_W-1:0]          d0_reg, d1_reg;
    logic [U_W-1:0]          u1_reg;
    logic [D_W-1:0]          ang_c, d0_next;
    logic [2*D_W-1:0]        dsq;
    logic [U_W-1:0]          u1_next;

    logic                    hv_reg   [HORNER_N];
    logic signed [MAG_W-1:0] hmag_reg [HORNER_N];
    logic [RANGE_W-1:0]      hrng_reg [HORNER_N];
    logic [D_W-1:0]          hd_reg   [HORNER_N];
    logic [U_W-1:0]          hu_reg   [HORNER_N];
    logic signed [ACC_W-1:0] hacc_reg [HORNER_N];

    // clamp to 0..pi
    always_comb
    begin
        if (phase_angle[ANG_W-1])
        begin
            ang_c = '0;
        end
        else if (D_W'(phase_angle) > PA)
        begin
            ang_c = PA;
        end
        else
        begin
            ang_c = D_W'(phase_angle);
        end
        d0_next = PA - ang_c;
    end

    assign dsq     = (2*D_W)'(d0_reg) * (2*D_W)'(d0_reg);
    assign u1_next = U_W'((dsq + U_RND) >> U_SH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_vld;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag0_reg <= std_mag;
        rng0_reg <= (range_m == '0) ? RANGE_W'(1) : range_m;
        d0_reg   <= d0_next;
        mag1_reg <= mag0_reg;
        rng1_reg <= rng0_reg;
        d1_reg   <= d0_reg;
        u1_reg   <= u1_next;
    end

    for (genvar j = 0; j < HORNER_N; j++)
    begin : g_horner
        logic signed [ACC_W-1:0] acc_in;
        logic                    v_in;
        logic signed [MAG_W-1:0] mag_in;
        logic [RANGE_W-1:0]      rng_in;
        logic [D_W-1:0]          d_in;
        logic [U_W-1:0]          u_in;

        if (j == 0)
        begin : g_first
            assign acc_in = POLY_Q40[HORNER_N];
            assign v_in   = v1_reg;
            assign mag_in = mag1_reg;
            assign rng_in = rng1_reg;
            assign d_in   = d1_reg;
            assign u_in   = u1_reg;
        end
        else
        begin : g_next
            assign acc_in = hacc_reg[j-1];
            assign v_in   = hv_reg[j-1];
            assign mag_in = hmag_reg[j-1];
            assign rng_in = hrng_reg[j-1];
            assign d_in   = hd_reg[j-1];
            assign u_in   = hu_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hv_reg[j] <= 1'b0;
            end
            else
            begin
                hv_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            hacc_reg[j] <= horner_step(acc_in, u_in, POLY_Q40[HORNER_N-1-j]);
            hmag_reg[j] <= mag_in;
            hrng_reg[j] <= rng_in;
            hd_reg[j]   <= d_in;
            hu_reg[j]   <= u_in;
        end
    end

    assign out_vld   = hv_reg[HORNER_N-1];
    assign out_mag   = hmag_reg[HORNER_N-1];
    assign out_range = hrng_reg[HORNER_N-1];
    assign out_d     = hd_reg[HORNER_N-1];
    assign out_acc   = hacc_reg[HORNER_N-1];

endmodule

// File: rtl/core/samu_log2.sv
// pipelined log2: msb search then one mantissa squaring per stage
module samu_log2
    import samu_pkg::*;
(
    input  logic            clk,
    input  logic [LX_W-1:0] x,
    output log_res_t        res
);

    logic [P_W-1:0]    p_reg [LOG_FB+1];
    logic [MANT_W-1:0] m_reg [LOG_FB+1];
    logic [LOG_FB-1:0] f_reg [LOG_FB+1];
    logic [P_W-1:0]    p_next;
    logic [MANT_W-1:0] m_next;

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < LX_W; i++)
        begin
            if (x[i])
            begin
                p_next = P_W'(i);
            end
        end
        m_next = MANT_W'(((LX_W+MANT_W)'(x) << (MANT_W - 1)) >> p_next);
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= p_next;
        m_reg[0] <= m_next;
        f_reg[0] <= '0;
    end

    for (genvar i = 1; i <= LOG_FB; i++)
    begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;

        assign sq = (2*MANT_W)'(m_reg[i-1]) * (2*MANT_W)'(m_reg[i-1]);
        assign t  = sq[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge clk)
        begin
            p_reg[i] <= p_reg[i-1];
            m_reg[i] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
            f_reg[i] <= {f_reg[i-1][LOG_FB-2:0], t[MANT_W]};
        end
    end

    assign res.p    = p_reg[LOG_FB];
    assign res.frac = f_reg[LOG_FB];

endmodule

// File: rtl/core/samu_combine.sv
// log-domain sum, weighting, rounding and saturation
module samu_combine
    import samu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic signed [MAG_W-1:0] mag,
    input  logic                    use_poly,
    input  log_res_t                log_d,
    input  log_res_t                log_acc,
    input  log_res_t                log_rng,
    output logic                    done,
    output logic signed [OUT_W-1:0] apparent_mag
);

    logic                    v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [MAG_W-1:0] mag0_reg;
    logic signed [LV_W-1:0]  lf0_reg, lr0_reg;
    logic signed [SUM_W-1:0] mag1_reg, pr1_reg, pf1_reg, sum2_reg;
    logic signed [OUT_W-1:0] out_reg;

    logic signed [LV_W-1:0]  ld, la, lf_raw, lf_next;
    logic signed [SUM_W-1:0] sum_next, r_full;
    logic signed [OUT_W-1:0] out_next;

    always_comb
    begin
        ld     = log_value(log_d, ANGLE_FRAC_BITS);
        la     = log_value(log_acc, 40);
        lf_raw = ld + (ld <<< 1) + la;
        if (use_poly && (lf_raw > LOG2_FLOOR))
        begin
            lf_next = lf_raw;
        end
        else
        begin
            lf_next = LOG2_FLOOR;
        end
    end

    assign sum_next = mag1_reg + pr1_reg - pf1_reg - (SUM_W'(30) <<< SUM_FB);

    // half toward plus infinity, then clamp
    always_comb
    begin
        r_full = (sum2_reg + (SUM_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
        if (r_full < OUT_MIN)
        begin
            out_next = OUT_W'(OUT_MIN);
        end
        else if (r_full > OUT_MAX)
        begin
            out_next = OUT_W'(OUT_MAX);
        end
        else
        begin
            out_next = OUT_W'(r_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_vld;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag0_reg <= mag;
        lf0_reg  <= lf_next;
        lr0_reg  <= log_value(log_rng, 0);
        mag1_reg <= SUM_W'(mag0_reg) <<< (SUM_FB - MAG_FRAC_BITS);
        pr1_reg  <= SUM_W'(lr0_reg) * SUM_W'(K5);
        pf1_reg  <= SUM_W'(lf0_reg) * SUM_W'(K25);
        sum2_reg <= sum_next;
        if (v2_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign done         = v3_reg;
    assign apparent_mag = out_reg;

endmodule

// File: rtl/core/satellite_apparent_magnitude_unit.sv
// top level of the satellite apparent magnitude pipeline
//
// apparent visual magnitude of a satellite taken as a diffuse sphere: each beat
// carries a standard magnitude (q5.10), a slant range in metres and a phase angle
// (q3.16 radians), and yields std_mag + 5 log10(range) - 30 - 2.5 log10(f) in q8.10,
// saturating. a beat is taken whenever start is high; busy never rises, so a new
// beat may enter on every clock. each result appears on apparent_mag with done
// high for one cycle, in the order its beats were taken; the receiver cannot hold
// it off. the pipeline holds two stages of clamp and angle squaring, six horner
// stages for the phase polynomial, twenty-one stages of log2 (msb search plus one
// mantissa squaring per fraction bit) and four stages of weighting, summing and
// rounding.
module satellite_apparent_magnitude_unit
    import samu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [MAG_W-1:0] std_mag,
    input  logic [RANGE_W-1:0]      range_m,
    input  logic signed [ANG_W-1:0] phase_angle,
    output logic                    done,
    output logic signed [OUT_W-1:0] apparent_mag
);

    logic                    p_vld;
    logic signed [MAG_W-1:0] p_mag;
    logic [RANGE_W-1:0]      p_range;
    logic [D_W-1:0]          p_d;
    logic signed [ACC_W-1:0] p_acc;
    log_res_t                log_d, log_acc, log_rng;

    // sideband riding alongside the log2 units
    logic                    dv_reg   [LAT_LOG];
    logic                    duse_reg [LAT_LOG];
    logic signed [MAG_W-1:0] dmag_reg [LAT_LOG];

    // fully pipelined, never stalls
    assign busy = 1'b0;

    samu_poly u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (start),
        .std_mag     (std_mag),
        .range_m     (range_m),
        .phase_angle (phase_angle),
        .out_vld     (p_vld),
        .out_mag     (p_mag),
        .out_range   (p_range),
        .out_d       (p_d),
        .out_acc     (p_acc)
    );

    // log2 of pi less the clamped angle, the polynomial and the range in parallel lanes
    samu_log2 u_log_d (
        .clk (clk),
        .x   (LX_W'(p_d)),
        .res (log_d)
    );

    samu_log2 u_log_acc (
        .clk (clk),
        .x   (LX_W'(p_acc)),
        .res (log_acc)
    );

    samu_log2 u_log_rng (
        .clk (clk),
        .x   (LX_W'(p_range)),
        .res (log_rng)
    );

    for (genvar i = 0; i < LAT_LOG; i++)
    begin : g_side
        logic                    v_in, use_in;
        logic signed [MAG_W-1:0] mag_in;

        if (i == 0)
        begin : g_first
            // fully backlit or non-positive polynomial falls to the floor
            assign v_in   = p_vld;
            assign use_in = (p_d != '0) && !p_acc[ACC_W-1] && (p_acc != '0);
            assign mag_in = p_mag;
        end
        else
        begin : g_next
            assign v_in   = dv_reg[i-1];
            assign use_in = duse_reg[i-1];
            assign mag_in = dmag_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i] <= 1'b0;
            end
            else
            begin
                dv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            duse_reg[i] <= use_in;
            dmag_reg[i] <= mag_in;
        end
    end

    samu_combine u_comb (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (dv_reg[LAT_LOG-1]),
        .mag          (dmag_reg[LAT_LOG-1]),
        .use_poly     (duse_reg[LAT_LOG-1]),
        .log_d        (log_d),
        .log_acc      (log_acc),
        .log_rng      (log_rng),
        .done         (done),
        .apparent_mag (apparent_mag)
    );

endmodule

// File: rtl/core/samu_checker.sv
// port-level checker for the apparent magnitude pipeline, with its bind
module samu_checker
    import samu_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic signed [OUT_W-1:0] apparent_mag
);

    // the pipeline never refuses a beat
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every result traces back to a beat taken a fixed latency earlier
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching beat");

    // output holds between results
    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done && $past(rst_n) |-> $stable(apparent_mag))
        else $error("apparent_mag moved without done");

endmodule

bind satellite_apparent_magnitude_unit samu_checker u_samu_checker (.*);

// File: tb/satellite_apparent_magnitude_unit_tb.sv
// testbench for the satellite apparent magnitude pipeline, checked against a bit-exact predictor
`timescale 1ns / 100ps

module satellite_apparent_magnitude_unit_tb;
    import samu_pkg::*;

    localparam longint CYCLE_LIMIT = 200000;

    // horner coefficients of the diffuse phase polynomial, q.40
    localparam longint PHASE_POLY [7] = '{
        64'sd366503875925, -64'sd36650387593, 64'sd1308942414, -64'sd24239674,
        64'sd275451, -64'sd2119, 64'sd12
    };
    localparam longint FLOOR_LOG2F = -34832941;
    localparam longint W_RANGE     = 404035621;
    localparam longint W_PHASE     = 202017810;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [MAG_W-1:0] std_mag;
    logic [RANGE_W-1:0]      range_m;
    logic signed [ANG_W-1:0] phase_angle;
    logic                    done;
    logic signed [OUT_W-1:0] apparent_mag;

    // magnitudes still owed by the pipeline, oldest first
    logic signed [OUT_W-1:0] expected_mag [$];
    int     errors;
    longint cycle_count;
    bit     no_gaps;
    longint pi_q16;

    satellite_apparent_magnitude_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .std_mag      (std_mag),
        .range_m      (range_m),
        .phase_angle  (phase_angle),
        .done         (done),
        .apparent_mag (apparent_mag)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // product of signed values, magnitude rounded half away from zero
    function automatic longint round_mul(input longint a, input longint b, input int sh);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned p;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p  = (ua * ub + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // log2 of a nonzero integer in q.20, less a power-of-two scale
    function automatic longint log2_q20(input longint unsigned x, input int scale);
        int              msb;
        longint unsigned mant;
        longint          frac;
        msb  = 0;
        frac = 0;
        for (int i = 63; i > 0; i--)
        begin
            if (x[i] && msb == 0)
                msb = i;
        end
        mant = msb >= 30 ? x >> (msb - 30) : x << (30 - msb);
        // one mantissa squaring per fraction bit
        for (int i = 0; i < LOG_FB; i++)
        begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31))
            begin
                mant = mant >> 1;
                frac = frac | 1;
            end
        end
        return longint'(msb - scale) * (64'sd1 << LOG_FB) + frac;
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_magnitude(
        input logic signed [MAG_W-1:0] mag,
        input logic [RANGE_W-1:0]      rng,
        input logic signed [ANG_W-1:0] ang
    );
        longint          a;
        longint unsigned d;
        longint unsigned u;
        longint          acc;
        longint          log_f;
        longint          log_r;
        longint          total;
        longint          r;
        a     = ang;
        log_f = FLOOR_LOG2F;
        // clamp the phase to 0..pi
        if (a < 0)
            a = 0;
        if (a > pi_q16)
            a = pi_q16;
        d = pi_q16 - a;
        // fully backlit keeps the floor value
        if (d != 0)
        begin
            u   = (d * d + (64'd1 << (U_SH - 1))) >> U_SH;
            acc = PHASE_POLY[6];
            for (int k = 5; k >= 0; k--)
                acc = PHASE_POLY[k] + round_mul(acc, longint'(u), LOG_FB);
            if (acc > 0)
            begin
                log_f = 3 * log2_q20(d, ANGLE_FRAC_BITS) + log2_q20(acc, 40);
                if (log_f < FLOOR_LOG2F)
                    log_f = FLOOR_LOG2F;
            end
        end
        log_r = log2_q20(rng == 0 ? 64'd1 : 64'(rng), 0);
        total = longint'(mag) * (64'sd1 << (SUM_FB - MAG_FRAC_BITS)) + log_r * W_RANGE
              - log_f * W_PHASE - 30 * (64'sd1 << SUM_FB);
        // round half up, then saturate
        r = (total + (64'sd1 << (RND_SH - 1))) >>> RND_SH;
        if (r < -131072)
            r = -131072;
        if (r > 131071)
            r = 131071;
        return r[OUT_W-1:0];
    endfunction

    // one beat, with random idle cycles before it unless gaps are off
    task automatic send_beat(input logic signed [MAG_W-1:0] mag, input logic [RANGE_W-1:0] rng,
                             input logic signed [ANG_W-1:0] ang);
        if (!no_gaps)
        begin
            while ($urandom_range(99) < 29)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start       <= 1'b1;
        std_mag     <= mag;
        range_m     <= rng;
        phase_angle <= ang;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expected_mag.push_back(predict_magnitude(mag, rng, ang));
    endtask

    // ranges spread over every msb position
    function automatic logic [RANGE_W-1:0] random_range();
        int w;
        w = $urandom_range(1, RANGE_W);
        return RANGE_W'($urandom) & ((RANGE_W'(1) << w) - 1'b1) | (w == RANGE_W ? '0 : '0);
    endfunction

    task automatic test_directed();
        logic signed [ANG_W-1:0] edge_angles [10];
        edge_angles = '{-19'sd262144, -19'sd1, 19'sd0, 19'sd1, 19'sd102944,
                        ANG_W'(pi_q16 - 1), ANG_W'(pi_q16), ANG_W'(pi_q16 + 1),
                        19'sd262143, 19'sd205000};
        // every phase edge with mid-range magnitude and 1000 km
        foreach (edge_angles[i])
            send_beat(15'sd0, 30'd1000000, edge_angles[i]);
        // zero, unit and largest range
        send_beat(15'sd0, 30'd0, 19'sd65536);
        send_beat(15'sd0, 30'd1, 19'sd65536);
        send_beat(15'sd0, 30'h3FFFFFFF, 19'sd65536);
        // magnitude extremes, pushing toward both output limits
        send_beat(-15'sd16384, 30'd0, 19'sd0);
        send_beat(15'sd16383, 30'h3FFFFFFF, ANG_W'(pi_q16));
        send_beat(-15'sd16384, 30'h3FFFFFFF, -19'sd1);
        send_beat(15'sd16383, 30'd1, 19'sd262143);
        send_beat(15'sd1, 30'd2, ANG_W'(pi_q16 - 2));
    endtask

    task automatic test_random(input int count);
        logic signed [ANG_W-1:0] ang;
        for (int i = 0; i < count; i++)
        begin
            // long stretch back to back in the middle
            no_gaps = (i >= count / 3) && (i < count / 2);
            case ($urandom_range(9))
                0:       ang = ANG_W'($urandom);
                1:       ang = ANG_W'(pi_q16 - $urandom_range(0, 64));
                default: ang = ANG_W'($urandom_range(0, pi_q16));
            endcase
            send_beat(MAG_W'($urandom), random_range(), ang);
        end
        no_gaps = 1'b0;
    endtask

    // result checker, sampled on the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_mag.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, apparent_mag);
                errors++;
            end
            else
            begin
                if (apparent_mag !== expected_mag[0])
                begin
                    $display("%0t: apparent_mag mismatch, expected %0d, actual %0d",
                             $time, expected_mag[0], apparent_mag);
                    errors++;
                end
                void'(expected_mag.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        cycle_count = 0;
        no_gaps     = 1'b0;
        pi_q16      = longint'(PA64);
        rst_n       = 1'b0;
        start       = 1'b0;
        std_mag     = '0;
        range_m     = '0;
        phase_angle = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1130);
        start <= 1'b0;
        // drain the pipeline, then a little margin
        while (expected_mag.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0 && expected_mag.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
